>>> rtl/bavg_pkg.sv
// ----------------------------------------------------------------------------
// bavg_pkg: shared definitions of the block average downscaler
// Pixel and result payload types, register indexes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bavg_pkg;

	// Width of one color component.
	localparam int PIX_W = 8;

	// Quotient bits of the block mean; one divider iteration retires one.
	localparam int QUOT_W = 8;
	localparam int STEP_W = 3;

	// Row counter and height register.
	localparam int ROW_W = 10;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_LIMIT = 11'd1024;

	// Register reset values.
	localparam logic [4:0] BLOCK_SIZE_RESET = 5'd2;
	localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RESET = 11'd1024;
	localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RESET = 11'd1024;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	typedef struct packed {
		logic [PIX_W-1:0] in_red;
		logic [PIX_W-1:0] in_green;
		logic [PIX_W-1:0] in_blue;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_red;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_blue;
		logic             final_pixel;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic sum;
		logic div_step;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_block;
		logic row_last;
		logic div_done;
	} status_t;

endpackage

>>> rtl/bavg_stream_if.sv
// ----------------------------------------------------------------------------
// bavg_stream_if: valid/ready stream channel
// Carries valid, ready and a payload of type T between a source and a sink.
// ----------------------------------------------------------------------------
interface bavg_stream_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

>>> rtl/block_average_downscaler_top.sv
// ----------------------------------------------------------------------------
// block_average_downscaler_top: N by N box-filter downscaler for RGB pixels
// Averages each complete N by N block of a raster-order image into one pixel.
// ----------------------------------------------------------------------------
// Pixels enter one per transfer in raster order and each complete N by N block
// yields one truncated mean pixel, flagged final_pixel on the bottom-right
// block; partial blocks at the right and bottom edges are dropped. A pixel
// that does not end a block row segment leaves the controller idle. A pixel
// that ends a segment in a block's upper rows passes through the line-store
// read and then the column-sum write back. A pixel that completes a block
// passes through the line-store read, the sum, the iterations of the
// per-channel restoring divider (one quotient bit each) and the load of the
// output register, which waits while the output register stays occupied. New
// pixels are taken while a result waits in the output register. The line
// store needs no clearing after reset: each block row writes it before it is
// read. Any write to a configuration register restarts the frame.
module block_average_downscaler_top #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_BLOCK = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bavg_stream_if.sink                      pix_in,
	bavg_stream_if.source                    pix_out,
	input  logic                             cfg_we,
	input  logic [bavg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bavg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import bavg_pkg::*;

	cmd_t    cmd;
	status_t status;
	result_t result;
	logic    in_ready;
	logic    out_valid;

	// Controller.
	bavg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.out_ready (pix_out.ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Datapath.
	bavg_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_BLOCK (MAX_BLOCK)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pix_in.data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

	assign pix_in.ready = in_ready;
	assign pix_out.valid = out_valid;
	assign pix_out.data = result;

endmodule

>>> rtl/bavg_ram.sv
// ----------------------------------------------------------------------------
// bavg_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bavg_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/bavg_ctrl.sv
// ----------------------------------------------------------------------------
// bavg_ctrl: controller of the block average downscaler
// Sequences pixel acceptance, the column-sum update, the mean division and
// the hand-off of a finished result to the output register.
// ----------------------------------------------------------------------------
module bavg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_ready,
	input  bavg_pkg::status_t status,
	output logic              in_ready,
	output logic              out_valid,
	output bavg_pkg::cmd_t    cmd
);

	import bavg_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && status.need_block) begin
					state_next = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_next = status.row_last ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// Load the output register once it is free or being emptied.
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Output valid flag; a load wins over a transfer in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/bavg_datapath.sv
// ----------------------------------------------------------------------------
// bavg_datapath: datapath of the block average downscaler
// Configuration registers, raster position counters, row accumulators, the
// column-sum line store and three restoring dividers for the block means.
// ----------------------------------------------------------------------------
module bavg_datapath #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_BLOCK = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bavg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [bavg_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  bavg_pkg::pixel_t                      pixel,
	input  bavg_pkg::cmd_t                        cmd,
	output bavg_pkg::status_t                     status,
	output bavg_pkg::result_t                     result
);

	import bavg_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WEW = $clog2(MAX_WIDTH + 1);
	localparam int PW = $clog2(MAX_BLOCK);
	localparam int NW = $clog2(MAX_BLOCK + 1);
	localparam int AREA_W = 2 * NW;
	localparam int ACC_W = PIX_W + PW;
	localparam int SUM_W = PIX_W + 2 * PW;
	localparam int XW = ((CW > NW) ? CW : NW) + 2;
	localparam int RXW = ((ROW_W > NW) ? ROW_W : NW) + 2;
	localparam logic [7:0] MAXB = 8'(MAX_BLOCK);
	localparam logic [12:0] MAXW = 13'(MAX_WIDTH);

	// Configuration registers.
	logic [4:0]            bs_q;
	logic [CFG_DATA_W-1:0] w_q;
	logic [CFG_DATA_W-1:0] h_q;
	logic                  restart;

	// Position counters.
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [PW-1:0]    cphase_q;
	logic [PW-1:0]    rphase_q;
	logic [CW-1:0]    bcol_q;

	// Effective geometry.
	logic [NW-1:0]         n_eff;
	logic [NW-1:0]         n_m1;
	logic [WEW-1:0]        w_eff;
	logic [CFG_DATA_W-1:0] h_eff;
	logic [AREA_W-1:0]     area;

	// Position decode.
	logic cphase_end;
	logic rphase_end;
	logic in_block;
	logic col_wrap;
	logic row_wrap;
	logic last_col;
	logic last_row;

	// Accumulation and line store.
	logic [ACC_W-1:0]   acc_q [3];
	logic [PIX_W-1:0]   px [3];
	logic [CW-1:0]      ocol_q;
	logic               row_first_q;
	logic               row_last_q;
	logic               last_q;
	logic [3*SUM_W-1:0] ram_rd_data;
	logic [3*SUM_W-1:0] ram_wr_data;
	logic [SUM_W-1:0]   total [3];

	// Dividers.
	logic [AREA_W-1:0] rem_q [3];
	logic [QUOT_W-1:0] quo_q [3];
	logic [STEP_W-1:0] step_q;
	logic [AREA_W:0]   trial [3];
	logic              qbit [3];
	result_t           res_q;

	// Configuration writes; any write to a known register restarts the frame.
	assign restart = cfg_we && (cfg_index inside {REG_BLOCK_SIZE, REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= BLOCK_SIZE_RESET;
			w_q <= IMAGE_WIDTH_RESET;
			h_q <= IMAGE_HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_SIZE:   bs_q <= cfg_data[4:0];
				REG_IMAGE_WIDTH:  w_q <= cfg_data;
				REG_IMAGE_HEIGHT: h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the registers to their usable ranges; zero counts as one.
	always_comb begin
		if (bs_q == 5'd0) begin
			n_eff = NW'(1);
		end else if ({3'b000, bs_q} > MAXB) begin
			n_eff = NW'(MAX_BLOCK);
		end else begin
			n_eff = NW'(bs_q);
		end
		if (w_q == '0) begin
			w_eff = WEW'(1);
		end else if ({2'b00, w_q} > MAXW) begin
			w_eff = WEW'(MAX_WIDTH);
		end else begin
			w_eff = WEW'(w_q);
		end
		if (h_q == '0) begin
			h_eff = CFG_DATA_W'(1);
		end else if (h_q > HEIGHT_LIMIT) begin
			h_eff = HEIGHT_LIMIT;
		end else begin
			h_eff = h_q;
		end
	end

	assign n_m1 = n_eff - NW'(1);
	assign area = AREA_W'(n_eff) * AREA_W'(n_eff);

	// A pixel counts when its whole block lies inside the image.
	assign cphase_end = (NW'(cphase_q) == n_m1);
	assign rphase_end = (NW'(rphase_q) == n_m1);
	assign in_block = ((XW'(col_q) - XW'(cphase_q) + XW'(n_eff)) <= XW'(w_eff)) &&
		((RXW'(row_q) - RXW'(rphase_q) + RXW'(n_eff)) <= RXW'(h_eff));
	assign col_wrap = (XW'(col_q) + XW'(1)) >= XW'(w_eff);
	assign row_wrap = (RXW'(row_q) + RXW'(1)) >= RXW'(h_eff);
	assign last_col = (XW'(col_q) + XW'(1) + XW'(n_eff)) > XW'(w_eff);
	assign last_row = (RXW'(row_q) + RXW'(1) + RXW'(n_eff)) > RXW'(h_eff);

	// Raster position and block phase counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cphase_q <= '0;
			rphase_q <= '0;
			bcol_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			cphase_q <= '0;
			rphase_q <= '0;
			bcol_q <= '0;
		end else if (cmd.accept) begin
			if (col_wrap) begin
				col_q <= '0;
				cphase_q <= '0;
				bcol_q <= '0;
				if (row_wrap) begin
					row_q <= '0;
					rphase_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					rphase_q <= rphase_end ? '0 : rphase_q + PW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
				cphase_q <= cphase_end ? '0 : cphase_q + PW'(1);
				if (cphase_end) begin
					bcol_q <= bcol_q + CW'(1);
				end
			end
		end
	end

	assign px[0] = pixel.in_red;
	assign px[1] = pixel.in_green;
	assign px[2] = pixel.in_blue;

	// Row accumulators and the flags of a completed block row segment.
	always_ff @(posedge clk) begin
		if (cmd.accept && in_block) begin
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= (cphase_q == '0) ? ACC_W'(px[c]) : acc_q[c] + ACC_W'(px[c]);
			end
		end
		if (cmd.accept && in_block && cphase_end) begin
			ocol_q <= bcol_q;
			row_first_q <= (rphase_q == '0);
			row_last_q <= rphase_end;
			last_q <= last_col && last_row;
		end
	end

	// Column sums of the current block row, read at acceptance.
	bavg_ram #(
		.WIDTH (3 * SUM_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.wr_en   (cmd.sum && !row_last_q),
		.wr_addr (ocol_q),
		.wr_data (ram_wr_data),
		.rd_en   (cmd.accept),
		.rd_addr (bcol_q),
		.rd_data (ram_rd_data)
	);

	// Block totals: the first row starts fresh, later rows add the stored sum.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			total[c] = row_first_q ? SUM_W'(acc_q[c]) :
				ram_rd_data[c*SUM_W +: SUM_W] + SUM_W'(acc_q[c]);
			ram_wr_data[c*SUM_W +: SUM_W] = total[c];
		end
	end

	// One restoring division step per channel.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			trial[c] = {rem_q[c], quo_q[c][QUOT_W-1]};
			qbit[c] = (trial[c] >= {1'b0, area});
		end
	end

	// The mean fits in eight bits, so the upper total bits preload the remainder.
	always_ff @(posedge clk) begin
		if (cmd.sum && row_last_q) begin
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= AREA_W'(total[c] >> QUOT_W);
				quo_q[c] <= total[c][QUOT_W-1:0];
			end
			step_q <= '0;
		end else if (cmd.div_step) begin
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= qbit[c] ? AREA_W'(trial[c] - {1'b0, area}) : AREA_W'(trial[c]);
				quo_q[c] <= {quo_q[c][QUOT_W-2:0], qbit[c]};
			end
			step_q <= step_q + STEP_W'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.out_red <= quo_q[0];
			res_q.out_green <= quo_q[1];
			res_q.out_blue <= quo_q[2];
			res_q.final_pixel <= last_q;
		end
	end

	assign result = res_q;
	assign status.need_block = in_block && cphase_end;
	assign status.row_last = row_last_q;
	assign status.div_done = (step_q == STEP_W'(QUOT_W - 1));

endmodule

>>> rtl/bavg_checker.sv
// ----------------------------------------------------------------------------
// bavg_checker: port-level checks of the block average downscaler
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module bavg_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input bavg_pkg::result_t out_data
);

	// A held result keeps its value until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or vanished before its transfer");

	// A result is loaded only after the division, when no pixel is taken.
	a_load_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the input side was open");

	// The cycle before the load takes no pixel either: it belongs to the division or the wait for the output register.
	a_div_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready, 2))
		else $error("result appeared without a division ahead of it");

endmodule

bind block_average_downscaler_top bavg_checker u_bavg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_data  (pix_out.data)
);
